### rtl/pfc_pkg.sv
`default_nettype none
package pfc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PW = 32;                 // position width
  localparam int QW = 18;                 // quaternion field width
  localparam int MW = QW;                 // magnitude of a quaternion component
  localparam int SQW = 2 * MW;            // squared magnitude
  localparam int SW = SQW + 1;            // sum of four squares
  localparam int RW = 2 * FRAC_BITS + 42; // remainder and product width, signed
  localparam int RES_W = FRAC_BITS + 1;   // unsigned root ratio, 0..2^FRAC_BITS
  localparam int NSTG = FRAC_BITS + 1;    // one stage per result bit
  localparam int NLANE = 4;

  // lane order after the frame change: x, y (from z), z (from -y), w
  localparam int LX = 0;
  localparam int LY = 1;
  localparam int LZ = 2;
  localparam int LW = 3;

  typedef struct packed {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [PW-1:0] pz;
    logic [NLANE-1:0] neg;
    logic degen;
  } side_t;

  typedef struct packed {
    side_t side;
    logic [SW-1:0] sum;
    logic [NLANE-1:0][RW-1:0] rem0;
  } front_t;

endpackage
`default_nettype wire

### rtl/pfc_front.sv
`default_nettype none
module pfc_front (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_x,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_y,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_z,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_w,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_x,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_y,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_z,
  output pfc_pkg::front_t f
);
  import pfc_pkg::*;

  logic [PW-1:0] px1, py1, pz1, px2, py2, pz2;
  logic [NLANE-1:0][MW-1:0] mag1;
  logic [NLANE-1:0] neg1, neg2;
  logic [NLANE-1:0][SQW-1:0] sq2;
  logic [PW-1:0] pz_next;
  logic [NLANE-1:0][MW-1:0] mag_next;
  logic [NLANE-1:0] neg_next;
  logic [SW-1:0] sum_c;

  function automatic logic [MW-1:0] abs_q(input logic signed [QW-1:0] v);
    logic [MW-1:0] u;
    u = v;
    return v[QW-1] ? (~u + MW'(1)) : u;
  endfunction

  always_comb begin
    // negate y, saturating the most negative value
    pz_next = (pos_y == {1'b1, {(PW-1){1'b0}}}) ? {1'b0, {(PW-1){1'b1}}}
                                                : (~pos_y + PW'(1));
    mag_next[LX] = abs_q(quat_x);
    mag_next[LY] = abs_q(quat_z);
    mag_next[LZ] = abs_q(quat_y);
    mag_next[LW] = abs_q(quat_w);
    neg_next[LX] = quat_x[QW-1];
    neg_next[LY] = quat_z[QW-1];
    neg_next[LZ] = !quat_y[QW-1] && (quat_y != '0);
    neg_next[LW] = quat_w[QW-1];
  end

  always_comb begin
    sum_c = SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]) + SW'(sq2[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1 <= pos_x;
      py1 <= pos_z;
      pz1 <= pz_next;
      mag1 <= mag_next;
      neg1 <= neg_next;

      px2 <= px1;
      py2 <= py1;
      pz2 <= pz1;
      neg2 <= neg1;
      for (int l = 0; l < NLANE; l++) begin
        sq2[l] <= SQW'(mag1[l]) * SQW'(mag1[l]);
      end

      f.side.px <= px2;
      f.side.py <= py2;
      f.side.pz <= pz2;
      f.side.neg <= neg2;
      f.side.degen <= (sum_c == '0);
      f.sum <= sum_c;
      // remainder start: 4*m^2*2^(2F) - sum, for r = 0 (d = -1)
      for (int l = 0; l < NLANE; l++) begin
        f.rem0[l] <= (RW'(sq2[l]) << (2 * FRAC_BITS + 2)) - RW'(sum_c);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/pfc_lane.sv
`default_nettype none
module pfc_lane (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [pfc_pkg::SW-1:0] sum,
  input  wire logic [pfc_pkg::RW-1:0] rem0,
  output logic [pfc_pkg::RES_W-1:0] root
);
  import pfc_pkg::*;

  // rem = 4*m^2*2^(2F) - d^2*sum, prod = d*sum, d = 2*root - 1
  logic signed [RW-1:0] rem_q [NSTG];
  logic signed [RW-1:0] prod_q [NSTG];
  logic [SW-1:0] sum_q [NSTG];
  logic [RES_W-1:0] root_q [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam int K = FRAC_BITS - i;
    logic signed [RW-1:0] rem_c, prod_c, sum_w, addq, cand;
    logic [SW-1:0] sum_c;
    logic [RES_W-1:0] root_c;
    logic take;

    if (i == 0) begin : g_first
      assign rem_c = rem0;
      assign prod_c = -$signed(RW'(sum));
      assign sum_c = sum;
      assign root_c = '0;
    end else begin : g_rest
      assign rem_c = rem_q[i-1];
      assign prod_c = prod_q[i-1];
      assign sum_c = sum_q[i-1];
      assign root_c = root_q[i-1];
    end

    assign sum_w = $signed(RW'(sum_c));
    assign addq = (prod_c <<< (K + 2)) + (sum_w <<< (2 * K + 2));
    assign cand = rem_c - addq;
    // keep the bit where the ratio still fits, never past 2^FRAC_BITS
    assign take = !cand[RW-1] && !root_c[FRAC_BITS];

    always_ff @(posedge clk) begin
      if (en) begin
        sum_q[i] <= sum_c;
        if (take) begin
          rem_q[i] <= cand;
          prod_q[i] <= prod_c + (sum_w <<< (K + 1));
          root_q[i] <= root_c | (RES_W'(1) << K);
        end else begin
          rem_q[i] <= rem_c;
          prod_q[i] <= prod_c;
          root_q[i] <= root_c;
        end
      end
    end
  end

  assign root = root_q[NSTG-1];

endmodule
`default_nettype wire

### rtl/pose_frame_conversion_unit.sv
`default_nettype none
// Pipeline: three front stages (convert, square, sum), one stage per result bit of the
// root recurrence, one output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset: rst (synchronous) clears every valid bit; payload registers are not reset.
module pose_frame_conversion_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_x,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_y,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_z,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_w,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_x,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_y,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_z,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [pfc_pkg::PW-1:0] out_pos_x,
  output logic signed [pfc_pkg::PW-1:0] out_pos_y,
  output logic signed [pfc_pkg::PW-1:0] out_pos_z,
  output logic signed [pfc_pkg::QW-1:0] rot_x,
  output logic signed [pfc_pkg::QW-1:0] rot_y,
  output logic signed [pfc_pkg::QW-1:0] rot_z,
  output logic signed [pfc_pkg::QW-1:0] rot_w,
  output logic degenerate
);
  import pfc_pkg::*;

  localparam logic signed [RES_W:0] ONE = (RES_W + 1)'(1) << FRAC_BITS;

  logic en;
  logic [2:0] fv;
  logic [NSTG-1:0] lv;
  front_t f;
  side_t side_q [NSTG];
  logic [NLANE-1:0][RES_W-1:0] root;
  logic [NLANE-1:0][QW-1:0] rot_next;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  pfc_front u_front (
    .clk(clk), .en(en),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .f(f)
  );

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic signed [RES_W:0] sv;
    pfc_lane u_lane (
      .clk(clk), .en(en), .sum(f.sum), .rem0(f.rem0[l]), .root(root[l])
    );
    // apply the sign after rounding; identity on a zero norm
    assign sv = side_q[NSTG-1].neg[l] ? -$signed({1'b0, root[l]})
                                      : $signed({1'b0, root[l]});
    assign rot_next[l] = side_q[NSTG-1].degen ? ((l == LW) ? QW'(ONE) : '0) : QW'(sv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      lv <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      fv <= {fv[1:0], in_valid};
      lv <= {lv[NSTG-2:0], fv[2]};
      out_valid <= lv[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= f.side;
      for (int i = 1; i < NSTG; i++) begin
        side_q[i] <= side_q[i-1];
      end
      out_pos_x <= side_q[NSTG-1].px;
      out_pos_y <= side_q[NSTG-1].py;
      out_pos_z <= side_q[NSTG-1].pz;
      rot_x <= rot_next[LX];
      rot_y <= rot_next[LY];
      rot_z <= rot_next[LZ];
      rot_w <= rot_next[LW];
      degenerate <= side_q[NSTG-1].degen;
    end
  end

`ifndef ASSERT_OFF
  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> rot_x == '0 && rot_y == '0 && rot_z == '0
                                && rot_w == QW'(ONE))
    else $error("zero norm did not give the identity");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rot_w) && $stable(out_pos_z))
    else $error("result changed while held");

  a_mag_x: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> (rot_x <= QW'(ONE)) && (rot_x >= -QW'(ONE)))
    else $error("normalized x beyond unit magnitude");

  a_no_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held while output empty");
`endif

endmodule
`default_nettype wire

### tb/sv/pose_frame_checker.sv
`timescale 1ns / 1ps
module pose_frame_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_x,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_y,
  input  wire logic signed [pfc_pkg::PW-1:0] pos_z,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_w,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_x,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_y,
  input  wire logic signed [pfc_pkg::QW-1:0] quat_z,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic signed [pfc_pkg::PW-1:0] out_pos_x,
  input  wire logic signed [pfc_pkg::PW-1:0] out_pos_y,
  input  wire logic signed [pfc_pkg::PW-1:0] out_pos_z,
  input  wire logic signed [pfc_pkg::QW-1:0] rot_x,
  input  wire logic signed [pfc_pkg::QW-1:0] rot_y,
  input  wire logic signed [pfc_pkg::QW-1:0] rot_z,
  input  wire logic signed [pfc_pkg::QW-1:0] rot_w,
  input  wire logic degenerate,
  output int fail_count,
  output int pending
);
  import pfc_pkg::*;

  typedef struct {
    logic [PW-1:0] px, py, pz;
    logic [QW-1:0] rot [NLANE];
    logic degen;
  } pose_t;

  pose_t poses_due[$];

  assign pending = poses_due.size();

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  // largest r in [0, 2^F] with (2r-1)^2 * sum <= 4 * mag^2 * 2^(2F)
  function automatic logic [QW-1:0] unit_ratio(longint mag, longint sum);
    logic [127:0] lim, lhs, d;
    longint lo, hi, mid;
    lim = 128'(mag * mag) << (2 * FRAC_BITS + 2);
    lo = 0;
    hi = longint'(1) << FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      d = 128'(2 * mid - 1);
      lhs = d * d * 128'(sum);
      if (lhs <= lim) lo = mid;
      else hi = mid - 1;
    end
    return QW'(lo);
  endfunction

  function automatic logic [QW-1:0] norm_lane(longint v, longint sum);
    logic [QW-1:0] r;
    r = unit_ratio(v < 0 ? -v : v, sum);
    return v < 0 ? QW'(-r) : r;
  endfunction

  function automatic pose_t convert_pose();
    pose_t p;
    longint lane [NLANE];
    longint sum;
    p.px = pos_x;
    p.py = pos_z;
    p.pz = (pos_y == 32'h8000_0000) ? 32'h7fff_ffff : -pos_y;
    lane[LX] = longint'(quat_x);
    lane[LY] = longint'(quat_z);
    lane[LZ] = -longint'(quat_y);
    lane[LW] = longint'(quat_w);
    sum = 0;
    foreach (lane[i]) sum += lane[i] * lane[i];
    p.degen = (sum == 0);
    foreach (lane[i]) begin
      if (p.degen) p.rot[i] = (i == LW) ? QW'(longint'(1) << FRAC_BITS) : '0;
      else p.rot[i] = norm_lane(lane[i], sum);
    end
    return p;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    pose_t e;
    if (!rst) begin
      if (in_valid && in_ready) poses_due.insert(poses_due.size(), convert_pose());
      if (out_valid && out_ready) begin
        if (poses_due.size() == 0) begin
          $display("result with no request outstanding");
          fail_count++;
        end else begin
          e = poses_due.pop_front();
          if (out_pos_x !== e.px) report("out_pos_x", out_pos_x, e.px);
          if (out_pos_y !== e.py) report("out_pos_y", out_pos_y, e.py);
          if (out_pos_z !== e.pz) report("out_pos_z", out_pos_z, e.pz);
          if (rot_x !== e.rot[LX]) report("rot_x", rot_x, e.rot[LX]);
          if (rot_y !== e.rot[LY]) report("rot_y", rot_y, e.rot[LY]);
          if (rot_z !== e.rot[LZ]) report("rot_z", rot_z, e.rot[LZ]);
          if (rot_w !== e.rot[LW]) report("rot_w", rot_w, e.rot[LW]);
          if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
        end
      end
    end
  end
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pfc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 530;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready, degenerate;
  logic signed [PW-1:0] pos_x, pos_y, pos_z, out_pos_x, out_pos_y, out_pos_z;
  logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z, rot_x, rot_y, rot_z, rot_w;
  int fail_count, pending, tx_idle, rx_idle, quiet;

  pose_frame_conversion_unit DUT (.*);
  pose_frame_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [17:0] qw, logic [17:0] qx, logic [17:0] qy,
                           logic [17:0] qz);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [17:0] rand_quat(int kind);
    case (kind)
      0: return 18'($urandom);
      1: return 18'($urandom_range(8)) - 18'd4;
      2: return 18'($urandom_range(131072)) - 18'd65536;
      default: return ($urandom_range(1)) ? 18'h20000 : 18'h1ffff;
    endcase
  endfunction

  task automatic send_random();
    int kind;
    logic [17:0] q [4];
    kind = $urandom_range(9);
    kind = (kind < 4) ? 0 : (kind < 6) ? 1 : (kind < 9) ? 2 : 3;
    foreach (q[i]) q[i] = ($urandom_range(5) == 0) ? 18'd0 : rand_quat(kind);
    send_pose($urandom, ($urandom_range(15) == 0) ? 32'h8000_0000 : $urandom, $urandom,
              q[0], q[1], q[2], q[3]);
  endtask

  initial begin
    rst = 1; in_valid = 0; out_ready = 0; quiet = 0;
    pos_x = 0; pos_y = 0; pos_z = 0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    tx_idle = 24; rx_idle = 87;
    repeat (2) @(posedge clk);
    rst <= 0;

    // zero norm, extremes, lone components, ties on equal magnitudes
    send_pose(0, 0, 0, 0, 0, 0, 0);
    send_pose(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
    send_pose(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 18'h10000, 0, 0, 0);
    send_pose(1, 32'hffff_ffff, 0, 0, 18'h10000, 0, 0);
    send_pose(2, 1, 3, 0, 0, 18'h10000, 0);
    send_pose(4, 5, 6, 0, 0, 0, 18'h10000);
    send_pose(7, 8, 9, 18'h20000, 0, 0, 0);
    send_pose(7, 8, 9, 0, 18'h1ffff, 0, 0);
    send_pose(7, 8, 9, 0, 0, 18'h20000, 0);
    send_pose(7, 8, 9, 0, 0, 0, 18'h3ffff);
    send_pose(0, 0, 0, 18'h20000, 18'h20000, 18'h20000, 18'h20000);
    send_pose(0, 0, 0, 18'h1ffff, 18'h1ffff, 18'h1ffff, 18'h1ffff);
    send_pose(0, 0, 0, 18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000);
    send_pose(0, 0, 0, 1, 1, 1, 1);
    send_pose(0, 0, 0, 1, 0, 0, 18'h3ffff);
    send_pose(0, 0, 0, 3, 4, 0, 0);
    send_pose(0, 0, 0, 1, 1, 1, 0);
    send_pose(0, 0, 0, 18'h0b505, 0, 0, 18'h0b505);
    send_pose(0, 0, 0, 18'h3ffff, 18'h3ffff, 18'h20000, 1);

    repeat (ITEMS_PER_PHASE) send_random();
    // hold the sender until the pipeline has drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    tx_idle = 87; rx_idle = 24;
    repeat (ITEMS_PER_PHASE) send_random();
    tx_idle = 0; rx_idle = 0;
    repeat (ITEMS_PER_PHASE) send_random();
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (FRAC_BITS + 20) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
